[hw/rtl/wpf_pkg.sv]
`timescale 1ns / 1ps

package wpf_pkg;

  // Stream word widths.
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 128;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 3;
  localparam int CFG_W      = 32;

  // Iteration counts of the square root and divide units.
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 66;
  localparam int CNT_W      = 7;

  // Configuration register indexes.
  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // Item function codes.
  typedef logic [1:0] func_t;
  localparam func_t FN_LOAD  = 2'd0;
  localparam func_t FN_START = 2'd1;
  localparam func_t FN_TICK  = 2'd2;
  localparam func_t FN_STOP  = 2'd3;

  // Result event codes.
  typedef logic [2:0] ev_t;
  localparam ev_t EV_MOVING   = 3'd0;
  localparam ev_t EV_STARTED  = 3'd1;
  localparam ev_t EV_NEWTGT   = 3'd2;
  localparam ev_t EV_COMPLETE = 3'd3;
  localparam ev_t EV_STOPPED  = 3'd4;

  // Datapath operations.
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_LATCH      = 5'd1;
  localparam op_t OP_WRITE      = 5'd2;
  localparam op_t OP_START      = 5'd3;
  localparam op_t OP_START_TGT  = 5'd4;
  localparam op_t OP_STOP       = 5'd5;
  localparam op_t OP_BUDGET     = 5'd6;
  localparam op_t OP_BUDGET_SAT = 5'd7;
  localparam op_t OP_READ       = 5'd8;
  localparam op_t OP_FETCH      = 5'd9;
  localparam op_t OP_SQX        = 5'd10;
  localparam op_t OP_SQY        = 5'd11;
  localparam op_t OP_SQSUM      = 5'd12;
  localparam op_t OP_SQRT       = 5'd13;
  localparam op_t OP_LEN        = 5'd14;
  localparam op_t OP_MULX       = 5'd15;
  localparam op_t OP_MULY       = 5'd16;
  localparam op_t OP_DIV_INIT   = 5'd17;
  localparam op_t OP_DIV        = 5'd18;
  localparam op_t OP_ADDX       = 5'd19;
  localparam op_t OP_ADDY       = 5'd20;
  localparam op_t OP_REACH      = 5'd21;
  localparam op_t OP_COMPLETE   = 5'd22;
  localparam op_t OP_EMIT       = 5'd23;

  // Command from controller to datapath.
  typedef struct packed {
    op_t  op;
    ev_t  ev;
    logic tgt_cur;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic moving;
    logic next_lt_n;
    logic len_gt_budget;
    logic reached;
  } sts_t;

endpackage

[hw/rtl/wpf_ram.sv]
`timescale 1ns / 1ps

module wpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/wpf_ctrl.sv]
`timescale 1ns / 1ps

module wpf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [1:0]             in_func,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output wpf_pkg::cmd_t          cmd,
  input  wpf_pkg::sts_t          sts
);
  import wpf_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_START = 5'd2;
  localparam logic [4:0] S_BUD   = 5'd3;
  localparam logic [4:0] S_LOOP  = 5'd4;
  localparam logic [4:0] S_FETCH = 5'd5;
  localparam logic [4:0] S_SQX   = 5'd6;
  localparam logic [4:0] S_SQY   = 5'd7;
  localparam logic [4:0] S_SUM   = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_LEN   = 5'd10;
  localparam logic [4:0] S_CMP   = 5'd11;
  localparam logic [4:0] S_DIX   = 5'd12;
  localparam logic [4:0] S_DVX   = 5'd13;
  localparam logic [4:0] S_ADX   = 5'd14;
  localparam logic [4:0] S_MULY  = 5'd15;
  localparam logic [4:0] S_DIY   = 5'd16;
  localparam logic [4:0] S_DVY   = 5'd17;
  localparam logic [4:0] S_ADY   = 5'd18;
  localparam logic [4:0] S_EMIT  = 5'd19;

  logic [4:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  func_t            func_r, func_nxt;
  ev_t              ev_r, ev_nxt;
  logic             tgt_cur_r, tgt_cur_nxt;
  logic             ovalid_r, ovalid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  // Sequencer for one item.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    func_nxt    = func_r;
    ev_nxt      = ev_r;
    tgt_cur_nxt = tgt_cur_r;
    ovalid_nxt  = ovalid_r & ~out_tready;
    cmd.op      = OP_NONE;
    cmd.ev      = ev_r;
    cmd.tgt_cur = tgt_cur_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LATCH;
          func_nxt  = in_func;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (func_r)
          FN_LOAD: begin
            cmd.op    = OP_WRITE;
            state_nxt = S_IDLE;
          end
          FN_START: begin
            cmd.op    = OP_START;
            state_nxt = S_START;
          end
          FN_STOP: begin
            if (sts.moving) begin
              cmd.op      = OP_STOP;
              ev_nxt      = EV_STOPPED;
              tgt_cur_nxt = 1'b1;
              state_nxt   = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (sts.moving) begin
              cmd.op    = OP_BUDGET;
              state_nxt = S_BUD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_START: begin
        cmd.op      = OP_START_TGT;
        ev_nxt      = EV_STARTED;
        tgt_cur_nxt = 1'b0;
        state_nxt   = S_EMIT;
      end
      S_BUD: begin
        cmd.op    = OP_BUDGET_SAT;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (sts.next_lt_n) begin
          cmd.op    = OP_READ;
          state_nxt = S_FETCH;
        end else begin
          cmd.op      = OP_COMPLETE;
          ev_nxt      = EV_COMPLETE;
          tgt_cur_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_FETCH: begin
        cmd.op    = OP_FETCH;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = OP_SQY;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SQSUM;
        cnt_nxt   = CNT_W'(SQRT_STEPS - 1);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.op    = OP_LEN;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.len_gt_budget) begin
          cmd.op    = OP_MULX;
          state_nxt = S_DIX;
        end else begin
          cmd.op    = OP_REACH;
          state_nxt = S_LOOP;
        end
      end
      S_DIX: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DVX;
      end
      S_DVX: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_ADX;
        end
      end
      S_ADX: begin
        cmd.op    = OP_ADDX;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.op    = OP_MULY;
        state_nxt = S_DIY;
      end
      S_DIY: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DVY;
      end
      S_DVY: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_ADY;
        end
      end
      S_ADY: begin
        cmd.op      = OP_ADDY;
        ev_nxt      = sts.reached ? EV_NEWTGT : EV_MOVING;
        tgt_cur_nxt = 1'b0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        // Load the output register once it is free or being drained.
        if (!ovalid_r || out_tready) begin
          cmd.op     = OP_EMIT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ovalid_r  <= 1'b0;
      cnt_r     <= '0;
      func_r    <= FN_LOAD;
      ev_r      <= EV_MOVING;
      tgt_cur_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      cnt_r     <= cnt_nxt;
      func_r    <= func_nxt;
      ev_r      <= ev_nxt;
      tgt_cur_r <= tgt_cur_nxt;
    end
  end

endmodule

[hw/rtl/wpf_dpath.sv]
`timescale 1ns / 1ps

module wpf_dpath #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wpf_pkg::cmd_t                   cmd,
  output wpf_pkg::sts_t                   sts,
  input  logic [wpf_pkg::IN_DATA_W-1:0]   in_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [wpf_pkg::CFG_W-1:0]       cfg_wdata,
  output logic [wpf_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [wpf_pkg::OUT_USER_W-1:0]  out_ev
);
  import wpf_pkg::*;

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int NW = AW + 1;
  localparam int CW = (NW > 7) ? NW : 7;

  // Configuration.
  logic [31:0] speed_r;
  logic [6:0]  count_r;

  // Latched item fields.
  logic [5:0]  idx_r;
  logic [31:0] px_r, py_r, el_r;

  // Path state.
  logic [31:0]   cur_x_r, cur_y_r;
  logic [NW-1:0] next_r;
  logic          moving_r;
  logic          reached_r;

  // Working registers.
  logic [31:0] w_x_r, w_y_r;
  logic [32:0] ax_r, ay_r;
  logic        sx_r, sy_r;
  logic [31:0] budget_r;
  logic [32:0] len_r;
  logic [65:0] prod_r, sum_r, rad_r, dvd_r;
  logic [34:0] rem_r;
  logic [32:0] root_r, quot_r;
  logic [33:0] drem_r;

  // Output register payload.
  logic [31:0] o_px_r, o_py_r, o_tx_r, o_ty_r;
  ev_t         o_ev_r;

  assign out_data = {o_ty_r, o_tx_r, o_py_r, o_px_r};
  assign out_ev   = o_ev_r;

  // Waypoint count clamped to between 2 and the table size.
  logic [CW-1:0] cnt_ext, n_cl, idx_ext;
  always_comb begin
    cnt_ext = CW'(count_r);
    idx_ext = CW'(idx_r);
    if (cnt_ext < CW'(2)) begin
      n_cl = CW'(2);
    end else if (cnt_ext > CW'(MAX_WAYPOINTS)) begin
      n_cl = CW'(MAX_WAYPOINTS);
    end else begin
      n_cl = cnt_ext;
    end
  end

  assign sts.moving        = moving_r;
  assign sts.next_lt_n     = CW'(next_r) < n_cl;
  assign sts.len_gt_budget = len_r > {1'b0, budget_r};
  assign sts.reached       = reached_r;

  // Path table.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  assign ram_we    = (cmd.op == OP_WRITE) && !moving_r && (idx_ext < CW'(MAX_WAYPOINTS));
  assign ram_re    = (cmd.op == OP_START) || (cmd.op == OP_READ);
  assign ram_raddr = (cmd.op == OP_START) ? AW'(1) : next_r[AW-1:0];

  wpf_ram #(
    .WIDTH (64),
    .DEPTH (MAX_WAYPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata ({py_r, px_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier, operands chosen by the operation.
  logic [32:0] mul_a, mul_b;
  logic        mul_en;
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_BUDGET: begin
        mul_a = {1'b0, speed_r};
        mul_b = {1'b0, el_r};
      end
      OP_SQX: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
      OP_SQY: begin
        mul_a = ay_r;
        mul_b = ay_r;
      end
      OP_MULX: begin
        mul_a = ax_r;
        mul_b = {1'b0, budget_r};
      end
      OP_MULY: begin
        mul_a = ay_r;
        mul_b = {1'b0, budget_r};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Distance to the fetched waypoint.
  logic [32:0] dx, dy;
  assign dx = {ram_rdata[31], ram_rdata[31:0]} - {cur_x_r[31], cur_x_r};
  assign dy = {ram_rdata[63], ram_rdata[63:32]} - {cur_y_r[31], cur_y_r};

  // One square root digit step: two radicand bits per cycle.
  logic [36:0] sq_rem, sq_trial;
  logic        sq_ge;
  assign sq_rem   = {rem_r, rad_r[65:64]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  // One restoring division step: one dividend bit per cycle.
  logic [34:0] dv_rem, dv_div;
  logic        dv_ge;
  assign dv_rem = {drem_r, dvd_r[65]};
  assign dv_div = {2'b00, len_r};
  assign dv_ge  = dv_rem >= dv_div;

  // Signed partial moves.
  logic [31:0] step_x, step_y;
  assign step_x = sx_r ? (32'd0 - quot_r[31:0]) : quot_r[31:0];
  assign step_y = sy_r ? (32'd0 - quot_r[31:0]) : quot_r[31:0];

  // Control state: configuration and path progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      count_r   <= 7'd2;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      next_r    <= NW'(1);
      moving_r  <= 1'b0;
      reached_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED: speed_r <= cfg_wdata;
          default:   count_r <= cfg_wdata[6:0];
        endcase
      end
      case (cmd.op)
        OP_START: begin
          cur_x_r  <= px_r;
          cur_y_r  <= py_r;
          next_r   <= NW'(1);
          moving_r <= 1'b1;
        end
        OP_STOP, OP_COMPLETE: begin
          moving_r <= 1'b0;
        end
        OP_BUDGET_SAT: begin
          reached_r <= 1'b0;
        end
        OP_REACH: begin
          cur_x_r   <= w_x_r;
          cur_y_r   <= w_y_r;
          next_r    <= next_r + 1'b1;
          reached_r <= 1'b1;
        end
        OP_ADDX: begin
          cur_x_r <= cur_x_r + step_x;
        end
        OP_ADDY: begin
          cur_y_r <= cur_y_r + step_y;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the arithmetic units, latched item fields and output register.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_LATCH: begin
        idx_r <= in_data[5:0];
        px_r  <= in_data[37:6];
        py_r  <= in_data[69:38];
        el_r  <= in_data[101:70];
      end
      OP_START_TGT: begin
        w_x_r <= ram_rdata[31:0];
        w_y_r <= ram_rdata[63:32];
      end
      OP_BUDGET_SAT: begin
        budget_r <= (prod_r[63:48] != '0) ? 32'hFFFF_FFFF : prod_r[47:16];
      end
      OP_FETCH: begin
        w_x_r <= ram_rdata[31:0];
        w_y_r <= ram_rdata[63:32];
        sx_r  <= dx[32];
        sy_r  <= dy[32];
        ax_r  <= dx[32] ? (33'd0 - dx) : dx;
        ay_r  <= dy[32] ? (33'd0 - dy) : dy;
      end
      OP_SQY: begin
        sum_r <= prod_r;
      end
      OP_SQSUM: begin
        rad_r  <= sum_r + prod_r;
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_SQRT: begin
        rad_r <= {rad_r[63:0], 2'b00};
        if (sq_ge) begin
          rem_r  <= 35'(sq_rem - sq_trial);
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r  <= sq_rem[34:0];
          root_r <= {root_r[31:0], 1'b0};
        end
      end
      OP_LEN: begin
        len_r <= root_r;
      end
      OP_REACH: begin
        budget_r <= budget_r - len_r[31:0];
      end
      OP_DIV_INIT: begin
        dvd_r  <= prod_r;
        drem_r <= '0;
        quot_r <= '0;
      end
      OP_DIV: begin
        dvd_r <= {dvd_r[64:0], 1'b0};
        if (dv_ge) begin
          drem_r <= 34'(dv_rem - dv_div);
          quot_r <= {quot_r[31:0], 1'b1};
        end else begin
          drem_r <= dv_rem[33:0];
          quot_r <= {quot_r[31:0], 1'b0};
        end
      end
      OP_EMIT: begin
        o_px_r <= cur_x_r;
        o_py_r <= cur_y_r;
        o_tx_r <= cmd.tgt_cur ? cur_x_r : w_x_r;
        o_ty_r <= cmd.tgt_cur ? cur_y_r : w_y_r;
        o_ev_r <= cmd.ev;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/waypoint_path_follower_core.sv]
`timescale 1ns / 1ps

// Waypoint path follower. Configuration: speed (index 0) and waypoint
// count (index 1), written through cfg_we/cfg_index/cfg_wdata while idle.
// Input words carry a function in in_tuser: load a waypoint into the table,
// start at a position, tick by an elapsed time, or stop. Load and ignored
// items give no result; start, stop, ticks while moving give one result
// word on the out_ channel with position, target and event code.
// One item is worked at a time. A tick examines waypoints in turn (one
// 33-step square root each), then makes the final partial move (two 66-step
// divides) or the check that completes the path, and then loads the
// output register. The square root and divide units are bit-serial, and
// that sets the tick time.
// The output register holds a finished word while the receiver stalls; the
// next item is accepted meanwhile, and its own result waits until the
// register is free. Reset clears the position to 0,0, selects waypoint 1,
// goes idle and sets speed 0 and count 2; the path table is not cleared.
module waypoint_path_follower_core #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // waypoint_index[5:0], point_x[37:6], point_y[69:38], elapsed[101:70]
  input  logic [wpf_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[1:0]
  input  logic [wpf_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // position_x[31:0], position_y[63:32], target_x[95:64], target_y[127:96]
  output logic [wpf_pkg::OUT_DATA_W-1:0]   out_tdata,
  // event_res[2:0]
  output logic [wpf_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [wpf_pkg::CFG_W-1:0]        cfg_wdata
);
  import wpf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  wpf_dpath #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata),
    .out_ev    (out_tuser)
  );

endmodule
